### hw/rtl/ssca_pkg.sv
// shared record type and widths for the circle area sorter
package ssca_pkg;

   localparam int unsigned COORD_W = 32;
   localparam int unsigned KEY_W   = 2 * COORD_W;

   typedef struct packed {
      logic        [COORD_W-1:0] radius;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_x;
   } rec_type;

   localparam int unsigned REC_W = $bits(rec_type);

endpackage

### hw/rtl/ssca_store.sv
// record store: one write port, one read port with registered read data
module ssca_store #(
   parameter int unsigned  DEPTH = 64,
   localparam int unsigned AW    = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  ssca_pkg::rec_type wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output ssca_pkg::rec_type rd_data
);

   ssca_pkg::rec_type mem [DEPTH];
   ssca_pkg::rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/shell_sort_circles_by_area_core.sv
// circle record loader, shell sort by area (knuth gaps) and sorted emitter
//
//   channel  dir  tdata (low bit up)                    tlast
//   req_     in   center_x, center_y, radius (96 bits)  last_record
//   rsp_     out  out_x, out_y, out_radius (96 bits)    end_of_set
//
// loading accepts one request per cycle; a request flagged last starts the sort
// sort: each outer step reads and holds a record, then shifts records up by the gap;
// the pace is set by the single store read port and the registered key square
// emission reads each record, registers it and holds it through any stall on rsp_tready
// reset is synchronous; the store needs no clearing, only entries below the count are read
module shell_sort_circles_by_area_core #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // center_x, center_y, radius
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // out_x, out_y, out_radius
   output logic        rsp_tlast
);

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned GW = CW + 1;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_GAP   = 4'd1;
   localparam logic [3:0] S_OUTER = 4'd2;
   localparam logic [3:0] S_HWAIT = 4'd3;
   localparam logic [3:0] S_HKEY  = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_CWAIT = 4'd6;
   localparam logic [3:0] S_CMP   = 4'd7;
   localparam logic [3:0] S_ERD   = 4'd8;
   localparam logic [3:0] S_EWAIT = 4'd9;
   localparam logic [3:0] S_EOUT  = 4'd10;

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [GW-1:0] gap_ff, gap_in;
   logic [GW-1:0] limit_ff, limit_in;
   logic [GW-1:0] outer_ff, outer_in;
   logic [GW-1:0] inner_ff, inner_in;
   ssca_pkg::rec_type held_ff, held_in;
   logic [ssca_pkg::KEY_W-1:0] hkey_ff, hkey_in;
   logic [ssca_pkg::KEY_W-1:0] prod_ff, prod_in;
   ssca_pkg::rec_type rsp_data_ff, rsp_data_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   ssca_pkg::rec_type wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   ssca_pkg::rec_type rd_q;

   logic              req_fire;
   logic              has_room;
   logic [CW-1:0]     count_next;
   logic [GW+1:0]     gap_grow;
   logic [GW-1:0]     inner_less;
   logic [GW-1:0]     count_ext;

   ssca_store #(.DEPTH(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_q)
   );

   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign has_room   = (count_ff < CAP_C);
   assign count_next = has_room ? count_ff + 1'b1 : count_ff;
   assign gap_grow   = {2'b00, gap_ff} + {1'b0, gap_ff, 1'b0} + 1'b1;
   assign inner_less = inner_ff - gap_ff;
   assign count_ext  = {1'b0, count_ff};
   assign prod_in    = rd_q.radius * rd_q.radius;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      gap_in       = gap_ff;
      limit_in     = limit_ff;
      outer_in     = outer_ff;
      inner_in     = inner_ff;
      held_in      = held_ff;
      hkey_in      = hkey_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = inner_ff[AW-1:0];
      wr_data      = held_ff;
      rd_en        = 1'b0;
      rd_addr      = outer_ff[AW-1:0];
      case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               wr_en    = has_room;
               wr_addr  = count_ff[AW-1:0];
               wr_data  = ssca_pkg::rec_type'(req_tdata);
               count_in = count_next;
               if (req_tlast) begin
                  gap_in   = GW'(1);
                  limit_in = {1'b0, count_next} + GW'(2);
                  state_in = S_GAP;
               end
            end
         end
         S_GAP: begin
            if (gap_grow < {2'b00, limit_ff}) begin
               gap_in = gap_grow[GW-1:0];
            end else begin
               outer_in = gap_ff;
               state_in = S_OUTER;
            end
         end
         S_OUTER: begin
            if (outer_ff >= count_ext) begin
               if (gap_ff == GW'(1)) begin
                  outer_in = '0;
                  state_in = S_ERD;
               end else begin
                  limit_in = gap_ff;
                  gap_in   = GW'(1);
                  state_in = S_GAP;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = outer_ff[AW-1:0];
               inner_in = outer_ff;
               state_in = S_HWAIT;
            end
         end
         S_HWAIT: begin
            held_in  = rd_q;
            state_in = S_HKEY;
         end
         S_HKEY: begin
            hkey_in  = prod_ff;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (inner_ff >= gap_ff) begin
               rd_en    = 1'b1;
               rd_addr  = inner_less[AW-1:0];
               state_in = S_CWAIT;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = inner_ff[AW-1:0];
               wr_data  = held_ff;
               outer_in = outer_ff + 1'b1;
               state_in = S_OUTER;
            end
         end
         S_CWAIT: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            wr_en   = 1'b1;
            wr_addr = inner_ff[AW-1:0];
            if (prod_ff >= hkey_ff) begin
               wr_data  = rd_q;
               inner_in = inner_less;
               state_in = S_CHECK;
            end else begin
               wr_data  = held_ff;
               outer_in = outer_ff + 1'b1;
               state_in = S_OUTER;
            end
         end
         S_ERD: begin
            rd_en    = 1'b1;
            rd_addr  = outer_ff[AW-1:0];
            state_in = S_EWAIT;
         end
         S_EWAIT: begin
            rsp_data_in  = rd_q;
            rsp_valid_in = 1'b1;
            rsp_last_in  = ((outer_ff + 1'b1) == count_ext);
            state_in     = S_EOUT;
         end
         S_EOUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  outer_in = outer_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         gap_ff       <= GW'(1);
         limit_ff     <= '0;
         outer_ff     <= '0;
         inner_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         gap_ff       <= gap_in;
         limit_ff     <= limit_in;
         outer_ff     <= outer_in;
         inner_ff     <= inner_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      hkey_ff     <= hkey_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_rsp_in_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (state_ff == S_EOUT))
      else $error("response valid outside emit state");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request and response channels open together");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C)
      else $error("record count beyond capacity");

   a_gap_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUTER || state_ff == S_CHECK) |-> (gap_ff != '0))
      else $error("zero gap during sort");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && count_ff == '0))
      else $error("block not back to loading after last response");

endmodule

### dv/circle_area_scoreboard.sv
`timescale 1ns / 100ps
// scoreboard class that predicts the area order of circle sets and checks each emitted record
package circle_area_sb_pkg;

   class circle_order_checker;
      int unsigned       capacity;
      ssca_pkg::rec_type loaded[];
      int unsigned       loaded_count;
      ssca_pkg::rec_type sorted_circles[$];
      logic              sorted_ends[$];
      int unsigned       errors;
      int unsigned       requests_seen;
      int unsigned       circles_checked;
      int unsigned       sets_sorted;
      int unsigned       dropped;

      function new(int unsigned cap);
         capacity        = cap;
         loaded          = new[cap];
         loaded_count    = 0;
         errors          = 0;
         requests_seen   = 0;
         circles_checked = 0;
         sets_sorted     = 0;
         dropped         = 0;
      endfunction

      function logic [63:0] area_key(ssca_pkg::rec_type c);
         logic [63:0] r;
         r = 64'(c.radius);
         return r * r;
      endfunction

      // gapped insertion with knuth gaps, earlier equal keys move past the held one
      function void sort_by_area();
         int                n;
         int                step;
         int                i;
         ssca_pkg::rec_type held;
         logic [63:0]       held_key;
         n    = int'(loaded_count);
         step = 1;
         while (step <= n / 3) step = step * 3 + 1;
         while (step > 0) begin
            for (int o = step; o < n; o++) begin
               held     = loaded[o];
               held_key = area_key(held);
               i        = o;
               while (i >= step && area_key(loaded[i - step]) >= held_key) begin
                  loaded[i] = loaded[i - step];
                  i         = i - step;
               end
               loaded[i] = held;
            end
            step = (step - 1) / 3;
         end
      endfunction

      function void note_request(ssca_pkg::rec_type rec, logic last);
         requests_seen++;
         if (loaded_count < capacity) begin
            loaded[loaded_count] = rec;
            loaded_count++;
         end else begin
            dropped++;
         end
         if (last) begin
            sort_by_area();
            for (int k = 0; k < int'(loaded_count); k++) begin
               sorted_circles.push_back(loaded[k]);
               sorted_ends.push_back(k + 1 == int'(loaded_count));
            end
            sets_sorted++;
            loaded_count = 0;
         end
      endfunction

      function void check_response(ssca_pkg::rec_type got, logic got_end);
         ssca_pkg::rec_type want;
         logic              want_end;
         if (sorted_circles.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual x=%h y=%h r=%h last=%b",
                     $time, got.center_x, got.center_y, got.radius, got_end);
            errors++;
            return;
         end
         want     = sorted_circles.pop_front();
         want_end = sorted_ends.pop_front();
         circles_checked++;
         if (got.center_x !== want.center_x) begin
            $display("%0t: out_x expected %h actual %h", $time, want.center_x, got.center_x);
            errors++;
         end
         if (got.center_y !== want.center_y) begin
            $display("%0t: out_y expected %h actual %h", $time, want.center_y, got.center_y);
            errors++;
         end
         if (got.radius !== want.radius) begin
            $display("%0t: out_radius expected %h actual %h", $time, want.radius, got.radius);
            errors++;
         end
         if (got_end !== want_end) begin
            $display("%0t: end_of_set expected %b actual %b", $time, want_end, got_end);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return sorted_circles.size();
      endfunction
   endclass

endpackage

### dv/tb_top.sv
`timescale 1ns / 100ps
// top-level testbench for the circle area shell sorter
module tb_top;

   localparam int unsigned CAPACITY     = 64;
   localparam int unsigned ITEM_TARGET  = 420;
   localparam int unsigned QUIET_LIMIT  = 40000;
   localparam int unsigned DRAIN_CYCLES = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;

   logic        steady       = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned items_sent   = 0;
   circle_area_sb_pkg::circle_order_checker board;

   shell_sort_circles_by_area_core #(
      .CAPACITY(CAPACITY)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial forever #2 clock = ~clock;

   function automatic logic take_break();
      return !steady && ($urandom_range(99) < 12);
   endfunction

   function automatic ssca_pkg::rec_type make_circle(input logic [31:0] x,
                                                     input logic [31:0] y,
                                                     input logic [31:0] r);
      ssca_pkg::rec_type c;
      c.center_x = x;
      c.center_y = y;
      c.radius   = r;
      return c;
   endfunction

   function automatic logic [31:0] pick_radius();
      int unsigned sel;
      sel = $urandom_range(9);
      if (sel < 3) return $urandom_range(7);            // few keys, many ties
      if (sel < 7) return $urandom;
      if (sel < 9) return $urandom_range(32'h0010_0000);
      return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
   endfunction

   always @(negedge clock) begin
      rsp_tready <= reset ? 1'b0 : !take_break();
   end

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready)
            board.note_request(ssca_pkg::rec_type'(req_tdata), req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_response(ssca_pkg::rec_type'(rsp_tdata), rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no request or record moved for %0d cycles", $time, QUIET_LIMIT);
      $display("shell_sort_circles_by_area_core: mismatch");
      $finish;
   end

   task automatic send_request(input ssca_pkg::rec_type rec, input logic last);
      while (take_break()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rec;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_set(input int unsigned size);
      for (int unsigned k = 0; k < size; k++) begin
         send_request(make_circle($urandom, $urandom, pick_radius()), k + 1 == size);
      end
   endtask

   initial begin : stimulus
      int unsigned set_index;
      int unsigned set_size;
      board = new(CAPACITY);
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // single record with extreme fields
      send_request(make_circle(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF), 1'b1);
      // extremes, zero radius and equal keys mixed
      send_request(make_circle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000), 1'b0);
      send_request(make_circle(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
      send_request(make_circle(32'hFFFF_FFFF, 32'h0000_0000, 32'h0001_0000), 1'b0);
      send_request(make_circle(32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF), 1'b0);
      send_request(make_circle(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000), 1'b0);
      send_request(make_circle(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000), 1'b1);
      // descending radii
      for (int k = 0; k < 6; k++) begin
         send_request(make_circle(k, ~k, 32'h0006_0000 - k * 32'h0001_0000), k == 5);
      end
      // all keys equal
      for (int k = 0; k < 6; k++) begin
         send_request(make_circle(32'h1000_0000 + k, k, 32'h0002_8000), k == 5);
      end
      // two records already in order
      send_request(make_circle(32'h0000_0100, 32'h0000_0200, 32'h0000_0001), 1'b0);
      send_request(make_circle(32'h0000_0300, 32'h0000_0400, 32'h0000_0002), 1'b1);

      set_index = 0;
      while (items_sent < ITEM_TARGET) begin
         if (set_index == 2) set_size = CAPACITY;
         else if (set_index == 6) set_size = $urandom_range(CAPACITY + 8, CAPACITY + 1);
         else if (set_index == 20) set_size = $urandom_range(CAPACITY - 1, 2);
         else set_size = $urandom_range(10, 1);
         steady = (set_index >= 10 && set_index < 16);
         send_set(set_size);
         set_index++;
      end
      req_tvalid <= 1'b0;
      steady = 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d requests in %0d sets, %0d records dropped on a full store",
               board.requests_seen, board.sets_sorted, board.dropped);
      $display("checked %0d emitted records for area order and end-of-set marking",
               board.circles_checked);
      if (board.errors == 0) begin
         $display("shell_sort_circles_by_area_core: match");
      end else begin
         $display("shell_sort_circles_by_area_core: mismatch");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/ssca_pkg.sv
hw/rtl/ssca_store.sv
hw/rtl/shell_sort_circles_by_area_core.sv
dv/circle_area_scoreboard.sv
dv/tb_top.sv
